// ===== hdl/wfa_pkg.sv =====
// Package for the worst-fit block allocator.
// Holds the sizing constants, command codes and sequencer state type.
// No dependencies; used by worst_fit_block_allocator (wfa_ram does not use it).
package wfa_pkg;

   // Table geometry.
   localparam int NUM_BLOCKS = 32;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_BITS   = $clog2(NUM_BLOCKS);
   localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);

   // Width of the block count register.
   localparam int CSR_BITS   = 6;

   // Command codes carried in req_func.
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_ALLOC = 1'b1;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/wfa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
module wfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== hdl/worst_fit_block_allocator.sv =====
// Worst-fit block allocator: a table of block sizes in RAM, used marks in flops,
// and one comparator that scans the table under a small sequencer.
// Depends on wfa_pkg and wfa_ram.

// A load command (func 0) writes one block size and frees that block; it
// produces no result and leaves busy low. An allocate command (func 1) scans
// blocks 0 to min(block_count, 32) - 1 one entry per cycle through the single
// RAM read port and one subtract-and-compare unit, holding busy high until the
// scan and the commit are done; the result is shown in the first cycle with
// busy low. Each result is shown for exactly one cycle with rsp_valid high and
// cannot be held off by the receiver. The next command may be started in the
// same cycle the result is shown. Write block_count only while the block is
// idle.
module worst_fit_block_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [wfa_pkg::IDX_BITS-1:0]        req_block_index,
   input  logic [wfa_pkg::SIZE_BITS-1:0]       req_block_size,
   input  logic [wfa_pkg::SIZE_BITS-1:0]       req_request_size,
   output logic                                rsp_valid,
   output logic                                rsp_granted,
   output logic [wfa_pkg::IDX_BITS-1:0]        rsp_chosen_index,
   output logic [wfa_pkg::SIZE_BITS-1:0]       rsp_chosen_size,
   output logic [wfa_pkg::SIZE_BITS-1:0]       rsp_leftover,
   input  logic                                csr_wr_en,
   input  logic [wfa_pkg::CSR_BITS-1:0]        csr_wr_data
);

   // Sequencer and control state.
   wfa_pkg::state_type                 state_ff, state_in;
   logic [wfa_pkg::NUM_BLOCKS-1:0]     used_ff, used_in;
   logic [wfa_pkg::CSR_BITS-1:0]       count_ff;
   logic [wfa_pkg::CNT_BITS-1:0]       limit_ff, limit_in;
   logic [wfa_pkg::CNT_BITS-1:0]       issue_ff, issue_in;
   logic                               cmp_vld_ff, cmp_vld_in;
   logic                               found_ff, found_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [wfa_pkg::IDX_BITS-1:0]       cmp_idx_ff, cmp_idx_in;
   logic [wfa_pkg::SIZE_BITS-1:0]      req_ff, req_in;
   logic [wfa_pkg::IDX_BITS-1:0]       best_idx_ff, best_idx_in;
   logic [wfa_pkg::SIZE_BITS-1:0]      best_size_ff, best_size_in;
   logic [wfa_pkg::SIZE_BITS-1:0]      best_left_ff, best_left_in;
   logic                               rsp_granted_ff, rsp_granted_in;
   logic [wfa_pkg::IDX_BITS-1:0]       rsp_idx_ff, rsp_idx_in;
   logic [wfa_pkg::SIZE_BITS-1:0]      rsp_size_ff, rsp_size_in;
   logic [wfa_pkg::SIZE_BITS-1:0]      rsp_left_ff, rsp_left_in;

   // Combinational helpers.
   logic [wfa_pkg::CNT_BITS-1:0]       limit;
   logic                               issue_en;
   logic                               ram_we;
   logic [wfa_pkg::SIZE_BITS-1:0]      ram_rd_data;
   logic [wfa_pkg::SIZE_BITS:0]        diff;
   logic                               fits;
   logic [wfa_pkg::SIZE_BITS-1:0]      left;

   // Block size table.
   wfa_ram #(
      .WIDTH (wfa_pkg::SIZE_BITS),
      .DEPTH (wfa_pkg::NUM_BLOCKS)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_block_index),
      .wr_data (req_block_size),
      .rd_addr (issue_ff[wfa_pkg::IDX_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   // A count above the table depth scans the whole table.
   always_comb begin
      if (32'(count_ff) > wfa_pkg::NUM_BLOCKS) begin
         limit = wfa_pkg::CNT_BITS'(wfa_pkg::NUM_BLOCKS);
      end else begin
         limit = wfa_pkg::CNT_BITS'(count_ff);
      end
   end

   // The shared unit: one subtract gives fit and leftover for the entry read.
   assign diff     = {1'b0, ram_rd_data} - {1'b0, req_ff};
   assign fits     = ~diff[wfa_pkg::SIZE_BITS];
   assign left     = diff[wfa_pkg::SIZE_BITS-1:0];
   assign issue_en = (issue_ff < limit_ff);

   // Next state and outputs of the sequencer.
   always_comb begin
      state_in       = state_ff;
      used_in        = used_ff;
      limit_in       = limit_ff;
      issue_in       = issue_ff;
      cmp_vld_in     = cmp_vld_ff;
      cmp_idx_in     = cmp_idx_ff;
      found_in       = found_ff;
      req_in         = req_ff;
      best_idx_in    = best_idx_ff;
      best_size_in   = best_size_ff;
      best_left_in   = best_left_ff;
      rsp_valid_in   = 1'b0;
      rsp_granted_in = rsp_granted_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_size_in    = rsp_size_ff;
      rsp_left_in    = rsp_left_ff;
      ram_we         = 1'b0;
      busy           = (state_ff != wfa_pkg::ST_IDLE);

      case (state_ff)
         wfa_pkg::ST_IDLE: begin
            if (start) begin
               if (req_func == wfa_pkg::FUNC_LOAD) begin
                  // A load writes the size and frees the block at once.
                  ram_we                   = 1'b1;
                  used_in[req_block_index] = 1'b0;
               end else begin
                  req_in       = req_request_size;
                  limit_in     = limit;
                  issue_in     = '0;
                  cmp_vld_in   = 1'b0;
                  found_in     = 1'b0;
                  best_idx_in  = '0;
                  best_size_in = '0;
                  best_left_in = '0;
                  state_in     = wfa_pkg::ST_SCAN;
               end
            end
         end

         wfa_pkg::ST_SCAN: begin
            // Issue the next read address; its data arrives in the next cycle.
            if (issue_en) begin
               issue_in   = issue_ff + wfa_pkg::CNT_BITS'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[wfa_pkg::IDX_BITS-1:0];
            end else begin
               cmp_vld_in = 1'b0;
            end

            // Keep the largest leftover; a strict compare keeps the lowest index.
            if (cmp_vld_ff && !used_ff[cmp_idx_ff] && fits) begin
               if (!found_ff || (left > best_left_ff)) begin
                  found_in     = 1'b1;
                  best_idx_in  = cmp_idx_ff;
                  best_size_in = ram_rd_data;
                  best_left_in = left;
               end
            end

            if (!issue_en && !cmp_vld_ff) begin
               state_in = wfa_pkg::ST_DONE;
            end
         end

         wfa_pkg::ST_DONE: begin
            // Commit the choice and register the result.
            rsp_valid_in   = 1'b1;
            rsp_granted_in = found_ff;
            if (found_ff) begin
               used_in[best_idx_ff] = 1'b1;
               rsp_idx_in           = best_idx_ff;
               rsp_size_in          = best_size_ff;
               rsp_left_in          = best_left_ff;
            end else begin
               rsp_idx_in  = '0;
               rsp_size_in = '0;
               rsp_left_in = '0;
            end
            state_in = wfa_pkg::ST_IDLE;
         end

         default: begin
            state_in = wfa_pkg::ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wfa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         count_ff     <= '0;
         limit_ff     <= '0;
         issue_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         limit_ff     <= limit_in;
         issue_ff     <= issue_in;
         cmp_vld_ff   <= cmp_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmp_idx_ff     <= cmp_idx_in;
      req_ff         <= req_in;
      best_idx_ff    <= best_idx_in;
      best_size_ff   <= best_size_in;
      best_left_ff   <= best_left_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_size_ff    <= rsp_size_in;
      rsp_left_ff    <= rsp_left_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_chosen_index = rsp_idx_ff;
   assign rsp_chosen_size  = rsp_size_ff;
   assign rsp_leftover     = rsp_left_ff;

   // A result strobe only ever follows the commit state.
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == wfa_pkg::ST_DONE)
      else $error("result strobe without a commit");

   // A granted block is marked used when its result is shown.
   a_grant_marks_used: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_granted) |-> used_ff[rsp_chosen_index])
      else $error("granted block not marked used");

   // A refused request reports all fields as zero.
   a_no_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_granted) |->
         (rsp_chosen_index == '0 && rsp_chosen_size == '0 && rsp_leftover == '0))
      else $error("refused request with nonzero fields");

   // The leftover can never exceed the block it came from.
   a_left_bounded: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_granted) |-> rsp_leftover <= rsp_chosen_size)
      else $error("leftover larger than chosen block");

   // The compare stage is only live while scanning.
   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> state_ff == wfa_pkg::ST_SCAN)
      else $error("compare stage active outside the scan");

endmodule
